// File: hdl/assert_macros.svh
// assertion macros included by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert that an implication holds at each clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// assert that a condition holds at each clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`endif

// File: hdl/sacr_pkg.sv
// types and constants of the set-associative cache replacement controller
package sacr_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DECIDE,
    ST_SORT,
    ST_WRITE,
    ST_OUT
  } state_e;

  localparam logic POLICY_LFU  = 1'b0;
  localparam logic POLICY_MARK = 1'b1;

endpackage

// File: hdl/set_assoc_cache_replacement.sv
// top level: tag lookup, lfu with dynamic aging and randomized marking replacement
//
//   channel | direction | handshake      | payload
//   in      | input     | in_valid/stall | read_address, random_value
//   out     | output    | out_valid/stall| hit, set, way, offset, evicted, counters
//   cfg     | input     | valid/ready    | policy_mode
//
// a result passes set read, compare, the order list steps, write back and the
// result state after its transaction is taken
// the next transaction is taken only after the previous one has left the result state
// after reset a clearing pass initializes every entry of the set memory
// the next transaction is taken while a result waits in the output register
// a stalled result holds the block after the current write back
`include "assert_macros.svh"

module set_assoc_cache_replacement import sacr_pkg::*; #(
  parameter int SET_COUNT  = 64,
  parameter int WAYS       = 4,
  parameter int LINE_BYTES = 64,
  parameter int ADDR_BITS  = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [ADDR_BITS-1:0]   read_address_i,
  input  logic [15:0]            random_value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   hit_o,
  output logic [5:0]             set_number_o,
  output logic [1:0]             way_number_o,
  output logic [5:0]             byte_offset_o,
  output logic                   evicted_valid_o,
  output logic [31:0]            total_accesses_o,
  output logic [31:0]            total_misses_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_data_i
);

  localparam int OB  = $clog2(LINE_BYTES);
  localparam int IB  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int WB  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CB  = $clog2(WAYS + 1);
  localparam int TB  = ADDR_BITS - OB;
  localparam logic [IB:0] SETS_L = (IB+1)'(SET_COUNT);

  typedef struct packed {
    logic          valid;
    logic [TB-1:0] tag;
    logic [31:0]   age;
    logic [31:0]   uses;
    logic [WB-1:0] order;
  } line_t;

  typedef struct packed {
    line_t [WAYS-1:0] lines;
    logic  [CB-1:0]   marked;
  } entry_t;

  // set memory, one entry per set
  entry_t mem_q [SET_COUNT];
  entry_t rd_q;
  entry_t ent_q, ent_d;

  state_e state_q, state_d;
  logic   policy_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [15:0]          rnd_q;
  logic [IB-1:0]        set_q;
  logic [IB:0]          clr_q;
  logic [WB:0]          step_q, step_d;
  logic [WB-1:0]        pos_q, pos_d;
  logic [WB-1:0]        way_q, way_d;
  logic                 hit_q, hit_d, evict_q, evict_d, sort_q, sort_d;
  logic [31:0]          gage_q, gage_d, acc_q, miss_q;
  logic                 ov_q;
  logic [WB-1:0]        ord_q [WAYS];
  logic [WB-1:0]        ord_d [WAYS];

  logic [TB-1:0] tag_w;
  logic [IB-1:0] set_w;
  logic          in_acc, out_acc;

  // remainder of the random number by a small count, by reciprocal multiplication
  function automatic logic [WB-1:0] rem_small(logic [15:0] v, logic [CB-1:0] d);
    logic [21:0] m;
    logic [37:0] prod;
    logic [15:0] q, r;
    r = '0;
    for (int k = 1; k <= WAYS; k++) begin
      if (d == CB'(k)) begin
        m    = 22'(((32'd1 << 21) + 32'(k) - 32'd1) / 32'(k));
        prod = {22'd0, v} * {16'd0, m};
        q    = prod[36:21];
        r    = v - q * 16'(k);
      end
    end
    return WB'(r);
  endfunction

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = ov_q && !out_stall_i;
  assign tag_w   = TB'(addr_q >> (OB + IB));
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);

  // set index, reduced modulo the set count
  always_comb begin
    logic [IB:0] s;
    s = {1'b0, read_address_i[OB +: IB]};
    if (s >= SETS_L) s = s - SETS_L;
    set_w = s[IB-1:0];
    if (SET_COUNT == 1) set_w = '0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == (IB+1)'(SET_COUNT - 1)) state_d = ST_IDLE;
      ST_IDLE:   if (in_acc) state_d = ST_READ;
      ST_READ:   state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_SORT;
      ST_SORT:   if (!sort_q || step_q == (WB+1)'(WAYS)) state_d = ST_WRITE;
      ST_WRITE:  state_d = ST_OUT;
      ST_OUT:    if (!ov_q || out_acc) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath of one transaction
  always_comb begin
    logic          found, inv, allm;
    logic [WB-1:0] c, start;
    logic [WB:0]   ci;
    logic [CB-1:0] avail;
    logic [31:0]   pc, pp;
    ent_d = ent_q; way_d = way_q; hit_d = hit_q; evict_d = evict_q;
    gage_d = gage_q; sort_d = sort_q; pos_d = pos_q; step_d = step_q;
    for (int i = 0; i < WAYS; i++) ord_d[i] = ord_q[i];
    found = 1'b0; inv = 1'b0; allm = 1'b1; c = '0; start = '0; ci = '0;
    avail = '0; pc = '0; pp = '0;
    case (state_q)
      ST_DECIDE: begin
        ent_d = rd_q;
        for (int i = 0; i < WAYS; i++) ord_d[i] = rd_q.lines[i].order;
        hit_d = 1'b0; evict_d = 1'b0; sort_d = 1'b0; way_d = '0;
        for (int w = WAYS - 1; w >= 0; w--)
          if (rd_q.lines[w].valid && rd_q.lines[w].tag == tag_w) begin
            found = 1'b1; way_d = WB'(w);
          end
        if (found) begin
          hit_d = 1'b1;
          ent_d.lines[way_d].age = gage_q;
          if (policy_q == POLICY_LFU) begin
            ent_d.lines[way_d].uses = rd_q.lines[way_d].uses + 32'd1;
            sort_d = 1'b1;
          end
        end else begin
          for (int w = WAYS - 1; w >= 0; w--)
            if (!rd_q.lines[w].valid) begin
              inv = 1'b1; way_d = WB'(w);
            end
          if (inv) begin
            ent_d.lines[way_d].valid = 1'b1;
            ent_d.lines[way_d].uses  = 32'd1;
            if (policy_q == POLICY_LFU) begin
              ent_d.lines[way_d].age = gage_q;
              sort_d = 1'b1;
            end else if (rd_q.marked < CB'(WAYS)) begin
              ent_d.marked = rd_q.marked + CB'(1);
            end
          end else if (policy_q == POLICY_LFU) begin
            evict_d = 1'b1;
            way_d = rd_q.lines[WAYS-1].order;
            gage_d = rd_q.lines[way_d].age + rd_q.lines[way_d].uses;
            ent_d.lines[way_d].uses = 32'd1;
            ent_d.lines[way_d].age  = gage_d;
            sort_d = 1'b1;
          end else begin
            evict_d = 1'b1;
            for (int w = 0; w < WAYS; w++)
              if (rd_q.lines[w].uses == 32'd0) allm = 1'b0;
            if (rd_q.marked >= CB'(WAYS) || allm) begin
              for (int w = 0; w < WAYS; w++) ent_d.lines[w].uses = 32'd0;
              ent_d.marked = '0;
            end
            avail = CB'(WAYS) - ent_d.marked;
            start = rem_small(rnd_q, avail);
            way_d = start;
            found = 1'b0;
            for (int k = 0; k < WAYS; k++) begin
              // wrap the scan index around the way count
              ci = {1'b0, start} + (WB+1)'(k);
              if (ci >= (WB+1)'(WAYS)) ci = ci - (WB+1)'(WAYS);
              c = ci[WB-1:0];
              if (!found && ent_d.lines[c].uses == 32'd0) begin
                found = 1'b1; way_d = c;
              end
            end
            ent_d.lines[way_d].uses = ent_d.lines[way_d].uses + 32'd1;
            if (ent_d.marked < CB'(WAYS)) ent_d.marked = ent_d.marked + CB'(1);
          end
        end
        if (!hit_d) ent_d.lines[way_d].tag = tag_w;
        // locate the way in the order list
        pos_d = '0;
        for (int i = WAYS - 1; i >= 0; i--)
          if (rd_q.lines[i].order == way_d) pos_d = WB'(i);
        step_d = '0;
      end
      ST_SORT: begin
        // one insertion step per cycle
        if (sort_q) begin
          step_d = step_q + (WB+1)'(1);
          pc = ent_q.lines[way_q].age + ent_q.lines[way_q].uses;
          if (pos_q != '0) begin
            c  = ord_q[pos_q - WB'(1)];
            pp = ent_q.lines[c].age + ent_q.lines[c].uses;
            if (pp <= pc) begin
              ord_d[pos_q] = c;
              ord_d[pos_q - WB'(1)] = way_q;
              pos_d = pos_q - WB'(1);
            end else step_d = (WB+1)'(WAYS);
          end else step_d = (WB+1)'(WAYS);
        end
      end
      ST_WRITE: begin
        for (int i = 0; i < WAYS; i++) ent_d.lines[i].order = ord_q[i];
      end
      default: ;
    endcase
  end

  // set memory: synchronous read, single write port
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      entry_t z;
      z = '0;
      for (int i = 0; i < WAYS; i++) z.lines[i].order = WB'(i);
      mem_q[clr_q[IB-1:0]] <= z;
    end else if (state_q == ST_WRITE) begin
      mem_q[set_q] <= ent_d;
    end
    rd_q <= mem_q[set_q];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      addr_q <= read_address_i;
      rnd_q  <= random_value_i;
      set_q  <= set_w;
    end
    ent_q <= ent_d; way_q <= way_d; pos_q <= pos_d;
    for (int i = 0; i < WAYS; i++) ord_q[i] <= ord_d[i];
    if (state_q == ST_OUT && (!ov_q || out_acc)) begin
      hit_o           <= hit_q;
      set_number_o    <= 6'(set_q);
      way_number_o    <= 2'(way_q);
      byte_offset_o   <= 6'(addr_q[OB-1:0]);
      evicted_valid_o <= evict_q;
      total_accesses_o <= acc_q;
      total_misses_o   <= miss_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; clr_q <= '0; policy_q <= POLICY_LFU;
      gage_q <= '0; acc_q <= '0; miss_q <= '0; ov_q <= 1'b0;
      hit_q <= 1'b0; evict_q <= 1'b0; sort_q <= 1'b0; step_q <= '0;
    end else begin
      state_q <= state_d;
      hit_q <= hit_d; evict_q <= evict_d; sort_q <= sort_d; step_q <= step_d;
      gage_q <= gage_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + (IB+1)'(1);
      if (cfg_valid_i && cfg_ready_o) policy_q <= cfg_data_i;
      if (state_q == ST_DECIDE) begin
        acc_q <= acc_q + 32'd1;
        if (!hit_d) miss_q <= miss_q + 32'd1;
      end
      if (state_q == ST_OUT && (!ov_q || out_acc)) ov_q <= 1'b1;
      else if (out_acc) ov_q <= 1'b0;
    end
  end

  assign out_valid_o = ov_q;

  `ASSERT_IMPL(a_no_take_busy, clk_i, rst_ni, state_q != ST_IDLE, in_stall_o)
  `ASSERT_IMPL(a_evict_miss, clk_i, rst_ni, out_valid_o && evicted_valid_o, !hit_o)
  `ASSERT_IMPL(a_hit_no_miss, clk_i, rst_ni, state_q == ST_DECIDE && hit_d,
               ##1 miss_q == $past(miss_q))
  `ASSERT_IMPL(a_marked_range, clk_i, rst_ni, state_q == ST_WRITE, ent_q.marked <= CB'(WAYS))

endmodule

// File: sim/set_assoc_cache_replacement_tb.sv
// testbench of the cache replacement controller: reads checked against a behavioral model
`timescale 1ns / 1ps

module set_assoc_cache_replacement_tb import sacr_pkg::*; ();

  localparam int NSETS = 64;
  localparam int NWAYS = 4;

  typedef struct packed {
    logic        hit;
    logic [5:0]  set_num;
    logic [1:0]  way_num;
    logic [5:0]  offset;
    logic        evicted;
    logic [31:0] accesses;
    logic [31:0] misses;
  } lookup_t;

  // behavioral cache state and the queue of predicted lookups
  class lookup_board;
    logic        mode;
    bit          valid_q[NSETS][NWAYS];
    logic [19:0] tag_q[NSETS][NWAYS];
    logic [31:0] age_q[NSETS][NWAYS];
    logic [31:0] uses_q[NSETS][NWAYS];
    int          order_q[NSETS][NWAYS];
    int          marks_q[NSETS];
    logic [31:0] gage, n_acc, n_miss;
    lookup_t     pending[$];
    int          errors;

    function new();
      mode = POLICY_LFU;
      gage = 0; n_acc = 0; n_miss = 0; errors = 0;
      for (int s = 0; s < NSETS; s++) begin
        marks_q[s] = 0;
        for (int w = 0; w < NWAYS; w++) begin
          valid_q[s][w] = 0; tag_q[s][w] = 0; age_q[s][w] = 0;
          uses_q[s][w] = 0; order_q[s][w] = w;
        end
      end
    endfunction

    function logic [31:0] prio(int s, int w);
      return age_q[s][w] + uses_q[s][w];
    endfunction

    // move a way up the order list past entries of lower or equal priority
    function void promote(int s, int w);
      int pos;
      logic [31:0] cur;
      pos = NWAYS;
      cur = prio(s, w);
      for (int i = NWAYS - 1; i >= 0; i--) if (order_q[s][i] == w) pos = i;
      if (pos == NWAYS) return;
      while (pos > 0 && prio(s, order_q[s][pos-1]) <= cur) begin
        order_q[s][pos] = order_q[s][pos-1];
        pos--;
      end
      order_q[s][pos] = w;
    endfunction

    function void note_read(logic [31:0] addr, logic [15:0] rnd);
      lookup_t r;
      int s, w, start;
      logic [19:0] tg;
      bit all_marked, found;
      s = addr[11:6]; tg = addr[31:12];
      r = '0;
      r.set_num = addr[11:6]; r.offset = addr[5:0];
      w = 0;
      for (int i = NWAYS - 1; i >= 0; i--)
        if (valid_q[s][i] && tag_q[s][i] == tg) begin r.hit = 1; w = i; end
      n_acc++;
      if (r.hit) begin
        age_q[s][w] = gage;
        if (mode == POLICY_LFU) begin uses_q[s][w]++; promote(s, w); end
      end else begin
        n_miss++;
        found = 0;
        for (int i = NWAYS - 1; i >= 0; i--) if (!valid_q[s][i]) begin w = i; found = 1; end
        if (found) begin
          valid_q[s][w] = 1; uses_q[s][w] = 1;
          if (mode == POLICY_LFU) begin age_q[s][w] = gage; promote(s, w); end
          else if (marks_q[s] < NWAYS) marks_q[s]++;
        end else if (mode == POLICY_LFU) begin
          r.evicted = 1;
          w = order_q[s][NWAYS-1];
          gage = prio(s, w);
          uses_q[s][w] = 1; age_q[s][w] = gage;
          promote(s, w);
        end else begin
          r.evicted = 1;
          all_marked = 1;
          for (int i = 0; i < NWAYS; i++) if (uses_q[s][i] == 0) all_marked = 0;
          if (marks_q[s] >= NWAYS || all_marked) begin
            for (int i = 0; i < NWAYS; i++) uses_q[s][i] = 0;
            marks_q[s] = 0;
          end
          start = rnd % (NWAYS - marks_q[s]);
          w = start;
          for (int i = NWAYS - 1; i >= 0; i--)
            if (uses_q[s][(start + i) % NWAYS] == 0) w = (start + i) % NWAYS;
          uses_q[s][w]++;
          if (marks_q[s] < NWAYS) marks_q[s]++;
        end
        tag_q[s][w] = tg;
      end
      r.way_num = 2'(w); r.accesses = n_acc; r.misses = n_miss;
      pending.push_back(r);
    endfunction

    function void check_result(lookup_t act);
      lookup_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, act);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (act.hit !== exp_r.hit) report("hit", exp_r.hit, act.hit);
      if (act.set_num !== exp_r.set_num) report("set_number", exp_r.set_num, act.set_num);
      if (act.way_num !== exp_r.way_num) report("way_number", exp_r.way_num, act.way_num);
      if (act.offset !== exp_r.offset) report("byte_offset", exp_r.offset, act.offset);
      if (act.evicted !== exp_r.evicted) report("evicted_valid", exp_r.evicted, act.evicted);
      if (act.accesses !== exp_r.accesses)
        report("total_accesses", exp_r.accesses, act.accesses);
      if (act.misses !== exp_r.misses) report("total_misses", exp_r.misses, act.misses);
    endfunction

    function void report(string fld, logic [31:0] e, logic [31:0] a);
      $display("%0t: %s expected %0h actual %0h", $time, fld, e, a);
      errors++;
    endfunction
  endclass

  logic        clk_i = 0, rst_ni = 0;
  logic        in_valid_i = 0, out_stall_i = 0, cfg_valid_i = 0, cfg_data_i = 0;
  logic [31:0] read_address_i = 0;
  logic [15:0] random_value_i = 0;
  logic        in_stall_o, out_valid_o, cfg_ready_o;
  logic        hit_o, evicted_valid_o;
  logic [5:0]  set_number_o, byte_offset_o;
  logic [1:0]  way_number_o;
  logic [31:0] total_accesses_o, total_misses_o;

  lookup_board board = new();
  bit          calm;      // no idling on either side
  int          in_gap_pct = 8;

  set_assoc_cache_replacement dut (.*);

  always begin #6 clk_i = 1; #6 clk_i = 0; end

  // result side: random stall, sample at the rising edge
  always @(negedge clk_i) out_stall_i <= !calm && ($urandom_range(99) < 8);

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result({hit_o, set_number_o, way_number_o, byte_offset_o,
                          evicted_valid_o, total_accesses_o, total_misses_o});

  // valid stays up after a transaction until the next one or an idle cycle
  task automatic send_read(logic [31:0] addr, logic [15:0] rnd);
    while (!calm && $urandom_range(99) < in_gap_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1; read_address_i <= addr; random_value_i <= rnd;
    do @(posedge clk_i); while (in_stall_o);
    board.note_read(addr, rnd);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_policy(logic m);
    drain();
    cfg_valid_i <= 1; cfg_data_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.mode = m;
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // random address: mostly a few tags in a few sets to force evictions
  function automatic logic [31:0] pick_address();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(9) != 0) begin
      a[31:12] = 20'($urandom_range(5));
      a[11:6]  = 6'($urandom_range(3));
    end
    return a;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 3 && i < n / 2);
      send_read(pick_address(), 16'($urandom));
    end
    calm = 0;
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1;
    // directed: field extremes, hits, fills, lfu evictions, then marking evictions
    send_read(32'h0000_0000, 16'h0000);
    send_read(32'hFFFF_FFFF, 16'hFFFF);
    send_read(32'h0000_003F, 16'h0000);
    for (int t = 1; t <= 5; t++) send_read({20'(t), 6'd1, 6'd0}, 16'h0);
    send_read({20'd2, 6'd1, 6'd5}, 16'h0);
    send_read({20'd1, 6'd1, 6'd9}, 16'h0);
    write_policy(POLICY_MARK);
    for (int t = 1; t <= 7; t++) send_read({20'(t + 8), 6'd2, 6'd3}, 16'(t * 4099));
    send_read({20'hFFFFF, 6'd2, 6'd0}, 16'hFFFF);
    send_read({20'd3, 6'd1, 6'd0}, 16'h0);
    random_phase(400);
    // pause until every pending lookup returned
    drain();
    write_policy(POLICY_LFU);
    random_phase(450);
    write_policy(POLICY_MARK);
    random_phase(350);
    write_policy(POLICY_LFU);
    random_phase(300);
    drain();
    if (board.errors == 0) $display("set_assoc_cache_replacement: match");
    else $display("set_assoc_cache_replacement: mismatch");
    $finish;
  end

  initial begin
    #5ms;
    $display("set_assoc_cache_replacement: mismatch");
    $finish;
  end

endmodule
